// ===== hdl/sem_pkg.sv =====
// Shared types and constants for the Sobel edge magnitude stream.
`default_nettype none
package sem_pkg;

  localparam int PIX_W      = 8;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_WID_W  = 13;
  localparam int CFG_HGT_W  = 16;

  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_WIDTH  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_HEIGHT = 1'b1;

  localparam logic [CFG_WID_W-1:0] WIDTH_RST  = 13'd640;
  localparam logic [CFG_HGT_W-1:0] HEIGHT_RST = 16'd480;

  localparam logic [PIX_W-1:0] MAG_MAX = 8'd255;

  // One line-store word: the previous row and the row before it at one column.
  typedef struct packed {
    logic [PIX_W-1:0] row1;
    logic [PIX_W-1:0] row2;
  } line_pair_t;

endpackage
`default_nettype wire

// ===== hdl/sem_pixel_if.sv =====
// Stream interfaces for input pixels and for edge results.
`default_nettype none
interface sem_pixel_if;
  logic                        valid;
  logic                        ready;
  logic [sem_pkg::PIX_W-1:0]   pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface sem_result_if;
  logic                        valid;
  logic                        ready;
  logic [sem_pkg::PIX_W-1:0]   edge_res;
  logic                        frame_end;

  modport source (output valid, output edge_res, output frame_end, input ready);
  modport sink   (input valid, input edge_res, input frame_end, output ready);
endinterface
`default_nettype wire

// ===== hdl/sem_line_mem.sv =====
// Line store RAM holding the two previous rows, one write and one read port.
`default_nettype none
module sem_line_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  wire logic                clk,
  input  wire logic                we,
  input  wire logic [AW-1:0]       waddr,
  input  wire sem_pkg::line_pair_t wdata,
  input  wire logic                re,
  input  wire logic [AW-1:0]       raddr,
  output sem_pkg::line_pair_t      rdata_r
);

  sem_pkg::line_pair_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/sem_window.sv =====
// 3x3 pixel window with Sobel L1 magnitude of its current contents.
`default_nettype none
module sem_window (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       shift_en,
  input  wire logic [sem_pkg::PIX_W-1:0]  up2,
  input  wire logic [sem_pkg::PIX_W-1:0]  up1,
  input  wire logic [sem_pkg::PIX_W-1:0]  px,
  output logic      [sem_pkg::PIX_W-1:0]  mag
);

  logic [sem_pkg::PIX_W-1:0] win_r [9];
  logic [9:0]  gx_pos;
  logic [9:0]  gx_neg;
  logic [9:0]  gy_pos;
  logic [9:0]  gy_neg;
  logic [9:0]  gx_abs;
  logic [9:0]  gy_abs;
  logic [10:0] sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
    end else if (shift_en) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r*3]   <= win_r[r*3+1];
        win_r[r*3+1] <= win_r[r*3+2];
      end
      win_r[2] <= up2;
      win_r[5] <= up1;
      win_r[8] <= px;
    end
  end

  always_comb begin
    gx_pos = {2'b00, win_r[2]} + {1'b0, win_r[5], 1'b0} + {2'b00, win_r[8]};
    gx_neg = {2'b00, win_r[0]} + {1'b0, win_r[3], 1'b0} + {2'b00, win_r[6]};
    gy_pos = {2'b00, win_r[6]} + {1'b0, win_r[7], 1'b0} + {2'b00, win_r[8]};
    gy_neg = {2'b00, win_r[0]} + {1'b0, win_r[1], 1'b0} + {2'b00, win_r[2]};
    gx_abs = (gx_pos >= gx_neg) ? (gx_pos - gx_neg) : (gx_neg - gx_pos);
    gy_abs = (gy_pos >= gy_neg) ? (gy_pos - gy_neg) : (gy_neg - gy_pos);
    sum    = {1'b0, gx_abs} + {1'b0, gy_abs};
    mag    = (sum > {3'b000, sem_pkg::MAG_MAX}) ? sem_pkg::MAG_MAX : sum[7:0];
  end

endmodule
`default_nettype wire

// ===== hdl/sobel_edge_magnitude_stream.sv =====
// Top level of the streaming 3x3 Sobel edge magnitude filter.
// The block takes one pixel per clock cycle while the output is not stalled. Each result
// passes through the line-store read stage, the window update and the magnitude and output
// register, in that order. Both line stores share one RAM word per column, read when a pixel
// arrives and written back as that pixel leaves the read stage, so consecutive pixels never
// touch the same column at once. A frame of W x H pixels gives (W-1)*(H-1) results; the last
// one carries frame_end. Line-store contents after reset are not cleared, since only border
// results, which are forced to zero, can see unwritten entries. A configuration write
// restarts the frame and must happen while the block is idle.
`default_nettype none
module sobel_edge_magnitude_stream #(
  parameter int MAX_WIDTH = 4096
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  sem_pixel_if.sink                                in_pix,
  sem_result_if.source                             out_res,
  input  wire logic                                cfg_we,
  input  wire logic [sem_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  wire logic [sem_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int CW = $clog2(MAX_WIDTH);

  function automatic logic [CW-1:0] last_col_of(input logic [sem_pkg::CFG_WID_W-1:0] w);
    logic [CW-1:0] res;
    if (32'(w) > MAX_WIDTH) begin
      res = CW'(MAX_WIDTH - 1);
    end else if (w < 13'd3) begin
      res = CW'(2);
    end else begin
      res = CW'(w - 13'd1);
    end
    return res;
  endfunction

  function automatic logic [15:0] last_row_of(input logic [sem_pkg::CFG_HGT_W-1:0] h);
    return (h < 16'd3) ? 16'd2 : (h - 16'd1);
  endfunction

  logic [CW-1:0]  last_col_r;
  logic [15:0]    last_row_r;
  logic [CW-1:0]  col_r;
  logic [CW-1:0]  col_nxt;
  logic [15:0]    row_r;
  logic [15:0]    row_nxt;

  logic           accept;
  logic           s1_en;
  logic           s2_en;
  logic           out_en;

  logic                       s1_v_r;
  logic [sem_pkg::PIX_W-1:0]  s1_px_r;
  logic [CW-1:0]              s1_col_r;
  logic                       s1_emit_r;
  logic                       s1_border_r;
  logic                       s1_last_r;

  logic                       s2_v_r;
  logic                       s2_border_r;
  logic                       s2_last_r;

  logic                       out_valid_r;
  logic [sem_pkg::PIX_W-1:0]  out_edge_r;
  logic                       out_last_r;

  sem_pkg::line_pair_t        rd_pair;
  sem_pkg::line_pair_t        wr_pair;
  logic                       mem_we;
  logic [sem_pkg::PIX_W-1:0]  mag;

  assign out_en = !out_valid_r || out_res.ready;
  assign s2_en  = !s2_v_r || out_en;
  assign s1_en  = !s1_v_r || s2_en;
  assign accept = in_pix.valid && s1_en;
  assign mem_we = s1_v_r && s2_en;

  assign in_pix.ready      = s1_en;
  assign out_res.valid     = out_valid_r;
  assign out_res.edge_res  = out_edge_r;
  assign out_res.frame_end = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_col_r <= last_col_of(sem_pkg::WIDTH_RST);
      last_row_r <= last_row_of(sem_pkg::HEIGHT_RST);
    end else if (cfg_we) begin
      case (cfg_addr)
        sem_pkg::CFG_IDX_WIDTH: begin
          last_col_r <= last_col_of(cfg_wdata[sem_pkg::CFG_WID_W-1:0]);
        end
        sem_pkg::CFG_IDX_HEIGHT: begin
          last_row_r <= last_row_of(cfg_wdata[sem_pkg::CFG_HGT_W-1:0]);
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_we) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      if (col_r == last_col_r) begin
        col_nxt = '0;
        row_nxt = (row_r == last_row_r) ? 16'd0 : (row_r + 16'd1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_en) begin
      s1_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px_r     <= in_pix.pixel;
      s1_col_r    <= col_r;
      s1_emit_r   <= (row_r != 16'd0) && (col_r != '0);
      s1_border_r <= (row_r == 16'd1) || (col_r == CW'(1));
      s1_last_r   <= (row_r == last_row_r) && (col_r == last_col_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_en) begin
      s2_v_r <= s1_v_r && s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en) begin
      s2_border_r <= s1_border_r;
      s2_last_r   <= s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      out_edge_r <= s2_border_r ? '0 : mag;
      out_last_r <= s2_last_r;
    end
  end

  assign wr_pair.row1 = s1_px_r;
  assign wr_pair.row2 = rd_pair.row1;

  sem_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (s1_col_r),
    .wdata   (wr_pair),
    .re      (accept),
    .raddr   (col_r),
    .rdata_r (rd_pair)
  );

  sem_window u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (mem_we),
    .up2      (rd_pair.row2),
    .up1      (rd_pair.row1),
    .px       (s1_px_r),
    .mag      (mag)
  );

  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && accept) |-> (s1_col_r != col_r))
    else $error("line store read and write-back hit the same column");

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= last_col_r)
    else $error("column counter beyond the last column");

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_v_r)
    else $error("transferred pixel did not enter the read stage");

  a_border_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && s2_border_r && out_en) |=> (out_valid_r && out_edge_r == '0))
    else $error("border result is not zero");

endmodule
`default_nettype wire
